// ===== design/rsed_pkg.sv =====
// ============================================================================
// Range step edge detector package
// Shared widths, reset values and configuration register indexes.
// ============================================================================
`default_nettype none

package rsed_pkg;

  localparam int unsigned HALF_WINDOW_DEF = 10;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ARM_W      = 4;
  localparam int unsigned RUN_W      = 4;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [SAMPLE_W-1:0] AIR_HEIGHT_RST   = 16'd2000;
  localparam logic [ARM_W-1:0]    ARM_LIMIT_RST    = 4'd5;
  localparam logic [SAMPLE_W-1:0] CHANGE_THR_RST   = 16'd1000;
  localparam logic [RUN_W-1:0]    CONFIRM_RUNS_RST = 4'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AIR_HEIGHT   = 4'd0,
    REG_ARM_LIMIT    = 4'd1,
    REG_CHANGE_THR   = 4'd2,
    REG_CONFIRM_RUNS = 4'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== design/range_step_edge_detector_top.sv =====
// ============================================================================
// Range step edge detector
// Compares the sum of the newest half window of height samples with the sum
// of the half window before it and flags a downward step and its undoing.
// ============================================================================
// The sample channel takes one height beat per cycle on sample_valid with
// sample_stall low. Every sample gives exactly one result beat on the result
// channel, in order, carrying armed, above_wall, passed_wall and change_run.
// A result passes the s1, s2 and result registers after its sample is taken,
// and the block sustains one sample per cycle unless result_stall holds it:
// the ring of 2*HALF_WINDOW samples sits in a memory with two read ports, so
// the leaving and crossing samples of a beat are fetched together as it is taken.
// The result register holds its beat while result_stall is high; the whole
// pipeline freezes with it and sample_stall rises in the same cycle.
// Reset is synchronous. It clears the sums, counters and flags and restores
// the register defaults; the ring reads as zeros through a fill count, so no
// clearing pass is needed and samples are taken from the first cycle.
// Configuration writes are always taken (cfg_ready is high) and are meant
// for times when no sample is in flight. Indexes beyond the last register
// are ignored.
// ============================================================================
`default_nettype none

module range_step_edge_detector_top #(
  parameter int unsigned HALF_WINDOW = rsed_pkg::HALF_WINDOW_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,

  input  wire logic                             sample_valid,
  output logic                                  sample_stall,
  input  wire logic [rsed_pkg::SAMPLE_W-1:0]    height_mm,

  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic                                  armed,
  output logic                                  above_wall,
  output logic                                  passed_wall,
  output logic      [rsed_pkg::RUN_W-1:0]       change_run,

  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rsed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rsed_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned RING_DEPTH = 2 * HALF_WINDOW;
  localparam int unsigned ADDR_W     = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W      = rsed_pkg::SAMPLE_W + $clog2(HALF_WINDOW + 1);
  localparam int unsigned SW         = rsed_pkg::SAMPLE_W;
  localparam int unsigned AW         = rsed_pkg::ARM_W;
  localparam int unsigned RW         = rsed_pkg::RUN_W;

  logic [SW-1:0] air_height_mm;
  logic [AW-1:0] arm_limit;
  logic [SW-1:0] change_threshold_mm;
  logic [RW-1:0] confirm_runs;

  logic              accept;
  logic              adv;
  logic [ADDR_W-1:0] head_index;
  logic [ADDR_W-1:0] mid_index;
  logic [FILL_W-1:0] fill_count;

  logic          s1_valid;
  logic [SW-1:0] s1_height;
  logic          s1_leave_ok;
  logic          s1_cross_ok;
  logic [SW-1:0] rd_leave;
  logic [SW-1:0] rd_cross;

  logic [SW-1:0]    leave_val;
  logic [SW-1:0]    cross_val;
  logic [SUM_W-1:0] older_sum;
  logic [SUM_W-1:0] newer_sum;
  logic [SUM_W-1:0] older_sum_next;
  logic [SUM_W-1:0] newer_sum_next;
  logic [AW-1:0]    arm_count;
  logic [AW-1:0]    arm_count_next;

  logic             s2_valid;
  logic             s2_armed;
  logic [SUM_W-1:0] diff;
  logic [SUM_W-1:0] thr_scaled;
  logic             big_change;
  logic [RW-1:0]    run_step;
  logic             judge;
  logic [RW-1:0]    run_count;
  logic [RW-1:0]    run_count_next;
  logic             wall_flag;
  logic             wall_flag_next;
  logic             passed_next;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      air_height_mm       <= rsed_pkg::AIR_HEIGHT_RST;
      arm_limit           <= rsed_pkg::ARM_LIMIT_RST;
      change_threshold_mm <= rsed_pkg::CHANGE_THR_RST;
      confirm_runs        <= rsed_pkg::CONFIRM_RUNS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rsed_pkg::REG_AIR_HEIGHT:   air_height_mm       <= cfg_data[SW-1:0];
        rsed_pkg::REG_ARM_LIMIT:    arm_limit           <= cfg_data[AW-1:0];
        rsed_pkg::REG_CHANGE_THR:   change_threshold_mm <= cfg_data[SW-1:0];
        rsed_pkg::REG_CONFIRM_RUNS: confirm_runs        <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and ring addressing.
  assign adv          = !result_valid || !result_stall;
  assign sample_stall = !adv;
  assign accept       = sample_valid && !sample_stall;

  always_comb begin
    if (head_index >= ADDR_W'(HALF_WINDOW)) begin
      mid_index = head_index - ADDR_W'(HALF_WINDOW);
    end else begin
      mid_index = head_index + ADDR_W'(HALF_WINDOW);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      fill_count <= '0;
    end else if (accept) begin
      if (head_index == ADDR_W'(RING_DEPTH - 1)) begin
        head_index <= '0;
      end else begin
        head_index <= head_index + 1'b1;
      end
      if (fill_count != FILL_W'(RING_DEPTH)) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  rsed_ram #(
    .WIDTH (SW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .we      (accept),
    .waddr   (head_index),
    .wdata   (height_mm),
    .re      (accept),
    .raddr_a (head_index),
    .raddr_b (mid_index),
    .rdata_a (rd_leave),
    .rdata_b (rd_cross)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_height   <= height_mm;
      s1_leave_ok <= (fill_count == FILL_W'(RING_DEPTH));
      s1_cross_ok <= (fill_count >= FILL_W'(HALF_WINDOW));
    end
  end

  // Running sums and arming.
  assign leave_val = s1_leave_ok ? rd_leave : '0;
  assign cross_val = s1_cross_ok ? rd_cross : '0;

  always_comb begin
    older_sum_next = older_sum - SUM_W'(leave_val) + SUM_W'(cross_val);
    newer_sum_next = newer_sum - SUM_W'(cross_val) + SUM_W'(s1_height);
    arm_count_next = arm_count;
    if (s1_height > air_height_mm && arm_count <= arm_limit && arm_count != '1) begin
      arm_count_next = arm_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_sum <= '0;
      newer_sum <= '0;
      arm_count <= '0;
      s2_valid  <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        older_sum <= older_sum_next;
        newer_sum <= newer_sum_next;
        arm_count <= arm_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_armed <= (arm_count_next > arm_limit);
    end
  end

  // Run counting and step judgment.
  assign diff       = (older_sum > newer_sum) ? older_sum - newer_sum
                                              : newer_sum - older_sum;
  assign thr_scaled = SUM_W'(change_threshold_mm) * SUM_W'(HALF_WINDOW);
  assign big_change = diff > thr_scaled;

  always_comb begin
    if (!big_change) begin
      run_step = '0;
    end else if (run_count == '1) begin
      run_step = run_count;
    end else begin
      run_step = run_count + 1'b1;
    end
    judge          = (run_step == confirm_runs);
    run_count_next = run_count;
    wall_flag_next = wall_flag;
    passed_next    = 1'b0;
    if (s2_armed) begin
      run_count_next = judge ? '0 : run_step;
      if (judge) begin
        if (newer_sum < older_sum && !wall_flag) begin
          wall_flag_next = 1'b1;
        end else if (newer_sum > older_sum && wall_flag) begin
          wall_flag_next = 1'b0;
          passed_next    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count    <= '0;
      wall_flag    <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s2_valid;
      if (s2_valid) begin
        run_count <= run_count_next;
        wall_flag <= wall_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      armed       <= s2_armed;
      above_wall  <= wall_flag_next;
      passed_wall <= passed_next;
      change_run  <= run_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/rsed_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and two read ports with registered read data. A read of
// the address being written in the same cycle returns the old contents.
// ============================================================================
`default_nettype none

module rsed_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== verif/rsed_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Range step edge detector checker
// Watches the sample, result and register write channels of the detector.
// It keeps its own copy of the height ring, the running half-window sums,
// the arming and run counters and the wall flag. It predicts one result beat
// per accepted sample and compares every accepted result beat, field by
// field, with the oldest prediction.
// ============================================================================
module rsed_checker #(
  parameter int unsigned HALF_WINDOW = rsed_pkg::HALF_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            sample_valid,
  input  logic                            sample_stall,
  input  logic [rsed_pkg::SAMPLE_W-1:0]   height_mm,

  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic                            armed,
  input  logic                            above_wall,
  input  logic                            passed_wall,
  input  logic [rsed_pkg::RUN_W-1:0]      change_run,

  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rsed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsed_pkg::CFG_DATA_W-1:0] cfg_data,

  output int unsigned                     outstanding,
  output int unsigned                     error_count,
  output int unsigned                     results_checked,
  output int unsigned                     passes_seen
);

  localparam int unsigned SAMPLE_W   = rsed_pkg::SAMPLE_W;
  localparam int unsigned ARM_W      = rsed_pkg::ARM_W;
  localparam int unsigned RUN_W      = rsed_pkg::RUN_W;
  localparam int unsigned CFG_IDX_W  = rsed_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = rsed_pkg::CFG_DATA_W;
  localparam int unsigned RING_DEPTH = 2 * HALF_WINDOW;
  localparam int unsigned ARM_TOP    = 2 ** ARM_W - 1;
  localparam int unsigned RUN_TOP    = 2 ** RUN_W - 1;

  typedef struct packed {
    logic             armed;
    logic             above_wall;
    logic             passed_wall;
    logic [RUN_W-1:0] change_run;
  } step_report_t;

  logic [SAMPLE_W-1:0] air_height;
  logic [ARM_W-1:0]    arm_limit;
  logic [SAMPLE_W-1:0] change_thr;
  logic [RUN_W-1:0]    confirm_runs;

  logic [SAMPLE_W-1:0] height_ring [RING_DEPTH];
  int unsigned         head;
  int unsigned         newer_sum;
  int unsigned         older_sum;
  int unsigned         arm_count;
  int unsigned         run_count;
  logic                wall_flag;

  step_report_t        report_q [$];

  function automatic void clear_detector();
    air_height   = rsed_pkg::AIR_HEIGHT_RST;
    arm_limit    = rsed_pkg::ARM_LIMIT_RST;
    change_thr   = rsed_pkg::CHANGE_THR_RST;
    confirm_runs = rsed_pkg::CONFIRM_RUNS_RST;
    foreach (height_ring[i]) height_ring[i] = '0;
    head      = 0;
    newer_sum = 0;
    older_sum = 0;
    arm_count = 0;
    run_count = 0;
    wall_flag = 1'b0;
  endfunction

  function automatic void write_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      rsed_pkg::REG_AIR_HEIGHT:   air_height   = data[SAMPLE_W-1:0];
      rsed_pkg::REG_ARM_LIMIT:    arm_limit    = data[ARM_W-1:0];
      rsed_pkg::REG_CHANGE_THR:   change_thr   = data[SAMPLE_W-1:0];
      rsed_pkg::REG_CONFIRM_RUNS: confirm_runs = data[RUN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic step_report_t judge_sample(input logic [SAMPLE_W-1:0] x);
    int unsigned  mid;
    int unsigned  leaving;
    int unsigned  crossing;
    int unsigned  gap;
    logic         armed_now;
    logic         passed;
    step_report_t rep;
    mid      = (head + RING_DEPTH - HALF_WINDOW) % RING_DEPTH;
    leaving  = 32'(height_ring[head]);
    crossing = 32'(height_ring[mid]);
    // The crossing sample moves from the newer half into the older half.
    older_sum = older_sum - leaving + crossing;
    newer_sum = newer_sum - crossing + 32'(x);
    height_ring[head] = x;
    passed = 1'b0;

    if (x > air_height && arm_count <= 32'(arm_limit) && arm_count < ARM_TOP) begin
      arm_count++;
    end
    armed_now = (arm_count > 32'(arm_limit));

    if (armed_now) begin
      gap = (older_sum > newer_sum) ? older_sum - newer_sum : newer_sum - older_sum;
      if (gap > 32'(change_thr) * HALF_WINDOW) begin
        if (run_count < RUN_TOP) run_count++;
      end else begin
        run_count = 0;
      end
      if (run_count == 32'(confirm_runs)) begin
        if (newer_sum < older_sum && !wall_flag) begin
          wall_flag = 1'b1;
        end else if (newer_sum > older_sum && wall_flag) begin
          wall_flag = 1'b0;
          passed    = 1'b1;
        end
        run_count = 0;
      end
    end

    head = (head + 1 == RING_DEPTH) ? 0 : head + 1;

    rep.armed       = armed_now;
    rep.above_wall  = wall_flag;
    rep.passed_wall = passed;
    rep.change_run  = RUN_W'(run_count);
    return rep;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    step_report_t want;
    if (rst) begin
      clear_detector();
      report_q.delete();
      error_count     = 0;
      results_checked = 0;
      passes_seen     = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (report_q.size() == 0) begin
          $error("result beat arrived with no sample beat waiting for it");
          error_count++;
        end else begin
          want = report_q.pop_front();
          check_field("armed", 32'(want.armed), 32'(armed));
          check_field("above_wall", 32'(want.above_wall), 32'(above_wall));
          check_field("passed_wall", 32'(want.passed_wall), 32'(passed_wall));
          check_field("change_run", 32'(want.change_run), 32'(change_run));
          results_checked++;
          if (passed_wall) passes_seen++;
        end
      end
      if (cfg_valid && cfg_ready) write_setting(cfg_index, cfg_data);
      if (sample_valid && !sample_stall) report_q.push_back(judge_sample(height_mm));
    end
    outstanding <= report_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Range step edge detector testbench
// Drives height samples through the detector under a series of register
// settings, from the reset values to both extremes, with flight-like
// profiles (plateau, dip, recovery) mixed with random noise. Sender idling
// and receiver stalls vary per phase. The checker beside the block predicts
// and compares every result beat; this module makes stimulus and reports.
// ============================================================================
module tb_top;

  localparam int unsigned SAMPLE_W      = rsed_pkg::SAMPLE_W;
  localparam int unsigned RUN_W         = rsed_pkg::RUN_W;
  localparam int unsigned CFG_IDX_W     = rsed_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W    = rsed_pkg::CFG_DATA_W;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned DRAIN_PAUSE   = 8;
  localparam int unsigned PHASE_ITEMS   = 60;
  localparam int unsigned SETTING_COUNT = 8;
  localparam int unsigned MAX_HEIGHT    = 2 ** SAMPLE_W - 1;
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG =
    CFG_IDX_W'(rsed_pkg::REG_CONFIRM_RUNS + 1);

  logic                  clk;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_stall;
  logic [SAMPLE_W-1:0]   height_mm;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic                  armed;
  logic                  above_wall;
  logic                  passed_wall;
  logic [RUN_W-1:0]      change_run;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned outstanding;
  int unsigned error_count;
  int unsigned results_checked;
  int unsigned passes_seen;

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned samples_sent = 0;

  range_step_edge_detector_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .height_mm    (height_mm),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .armed        (armed),
    .above_wall   (above_wall),
    .passed_wall  (passed_wall),
    .change_run   (change_run),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rsed_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .height_mm       (height_mm),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .armed           (armed),
    .above_wall      (above_wall),
    .passed_wall     (passed_wall),
    .change_run      (change_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .outstanding     (outstanding),
    .error_count     (error_count),
    .results_checked (results_checked),
    .passes_seen     (passes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_height(input logic [SAMPLE_W-1:0] h);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    height_mm    <= h;
    do @(posedge clk); while (sample_stall);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic set_idle(input int unsigned mode);
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct <= 0;  end
      1: begin sender_idle_pct = 49; receiver_stall_pct <= 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct <= 49; end
      default: begin
        sender_idle_pct = 20;
        receiver_stall_pct <= 20;
      end
    endcase
  endtask

  task automatic apply_setting(input int unsigned phase);
    logic [CFG_DATA_W-1:0] air;
    logic [CFG_DATA_W-1:0] arm_lim;
    logic [CFG_DATA_W-1:0] thr;
    logic [CFG_DATA_W-1:0] confirm;
    case (phase)
      0: begin
        air = 16'd0;     arm_lim = 16'd0;    thr = 16'd0;     confirm = 16'd1;
      end
      1: begin
        air = 16'd65535; arm_lim = 16'd14;   thr = 16'd65535; confirm = 16'd15;
      end
      2: begin
        air = 16'd1000;  arm_lim = 16'hFFFF; thr = 16'd500;   confirm = 16'd3;
      end
      3: begin
        air = 16'd8000;  arm_lim = 16'd3;    thr = 16'd2000;  confirm = 16'd0;
      end
      5: begin
        air = 16'd500;   arm_lim = 16'd9;    thr = 16'd1500;  confirm = 16'd15;
      end
      7: begin
        air = 16'd2000;  arm_lim = 16'hA5F5; thr = 16'd1000;  confirm = 16'h3C05;
      end
      default: begin
        air     = CFG_DATA_W'($urandom_range(0, 30000));
        arm_lim = CFG_DATA_W'($urandom_range(0, 14));
        thr     = CFG_DATA_W'($urandom_range(0, 4000));
        confirm = CFG_DATA_W'($urandom_range(1, 8));
      end
    endcase
    write_reg(rsed_pkg::REG_AIR_HEIGHT, air);
    write_reg(rsed_pkg::REG_ARM_LIMIT, arm_lim);
    write_reg(rsed_pkg::REG_CHANGE_THR, thr);
    write_reg(rsed_pkg::REG_CONFIRM_RUNS, confirm);
    if (phase == 4) begin
      write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, 2 ** CFG_IDX_W - 1)),
                CFG_DATA_W'($urandom_range(0, MAX_HEIGHT)));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] wobble(input int unsigned level,
                                                 input int unsigned jit);
    int v;
    v = int'(level) + int'($urandom_range(0, 2 * jit)) - int'(jit);
    if (v < 0) v = 0;
    if (v > int'(MAX_HEIGHT)) v = int'(MAX_HEIGHT);
    return SAMPLE_W'(v);
  endfunction

  // A plateau, a dip onto the wall top and a recovery, each of random length.
  task automatic send_flight(output int unsigned sent);
    int unsigned base;
    int unsigned low;
    int unsigned jit;
    int unsigned hold;
    int unsigned dip;
    int unsigned back;
    base = $urandom_range(20000, MAX_HEIGHT);
    low  = $urandom_range(0, base - 1);
    jit  = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 400);
    hold = $urandom_range(2, 12);
    dip  = $urandom_range(4, 24);
    back = $urandom_range(4, 24);
    for (int unsigned i = 0; i < hold + dip + back; i++) begin
      send_height(wobble((i >= hold && i < hold + dip) ? low : base, jit));
    end
    sent = hold + dip + back;
  endtask

  task automatic send_noise(output int unsigned sent);
    sent = $urandom_range(1, 6);
    repeat (sent) send_height(SAMPLE_W'($urandom_range(0, MAX_HEIGHT)));
  endtask

  initial begin
    int unsigned n;
    int unsigned burst;
    rst          = 1'b1;
    sample_valid = 1'b0;
    height_mm    = '0;
    cfg_valid    = 1'b0;
    cfg_index    = rsed_pkg::REG_AIR_HEIGHT;
    cfg_data     = '0;
    set_idle(0);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Field extremes, then arming, a dip and a recovery under reset values.
    send_height(16'h0000);
    send_height(16'hFFFF);
    send_height(16'hAAAA);
    send_height(16'h5555);
    repeat (6) send_height(16'd5000);
    repeat (8) send_height(16'd100);
    repeat (7) send_height(16'd5000);

    for (int unsigned phase = 0; phase < SETTING_COUNT; phase++) begin
      drain();
      apply_setting(phase);
      set_idle(phase % 4);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) send_flight(burst);
        else send_noise(burst);
        n += burst;
      end
    end
    drain();

    $display("tb_top: %0d sample beats over %0d register settings and four idle patterns",
             samples_sent, SETTING_COUNT + 1);
    $display("tb_top: %0d result beats checked, %0d wall passes seen",
             results_checked, passes_seen);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
